// File: hdl/framed_byte_queue_core_assert.svh
// ----------------------------------------------------------------------------
// framed_byte_queue_core assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAMED_BYTE_QUEUE_CORE_ASSERT_SVH
`define FRAMED_BYTE_QUEUE_CORE_ASSERT_SVH

// ante holds at an edge -> cons holds at the same edge
`define FBQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds at an edge -> cons holds at the next edge
`define FBQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/fbq_pkg.sv
// ----------------------------------------------------------------------------
// fbq_pkg
// Types, constants and helpers shared by the framed byte queue modules.
// ----------------------------------------------------------------------------
package fbq_pkg;

	localparam int RING_DEPTH  = 256;
	localparam int PTR_W       = $clog2(RING_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  FRAME_HEAD      = 8'hEE;
	localparam logic [31:0] FRAME_TAIL      = 32'hFFFCFFFF;
	localparam logic [5:0]  MAX_FRAME_RESET = 6'd63;
	localparam logic [15:0] PENDING_MAX     = 16'hFFFF;

	// operation field codes
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} cmd_item_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] frame_byte;
		logic       last;
		logic       tail_seen;
		logic [5:0] frame_length;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_EXTRACT,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} queue_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DRAIN,
		BK_STATUS
	} back_state_t;

	function automatic ptr_t ring_next(input ptr_t p);
		if (p == ptr_t'(RING_DEPTH - 1)) begin
			return '0;
		end
		return p + ptr_t'(1);
	endfunction

endpackage

// File: hdl/fbq_front.sv
// ----------------------------------------------------------------------------
// fbq_front
// Takes commands, decodes the operation and queues valid ones.
// ----------------------------------------------------------------------------
module fbq_front (
	input  logic               start,
	input  fbq_pkg::cmd_item_t cmd,
	input  logic               q_full,
	output logic               busy,
	output logic               q_push,
	output fbq_pkg::queue_entry_t q_entry
);
	import fbq_pkg::*;

	logic      known;
	cmd_kind_t kind;

	always_comb begin
		known = 1'b1;
		kind  = CMD_PUSH;
		unique case (cmd.operation)
			OP_PUSH:    kind = CMD_PUSH;
			OP_EXTRACT: kind = CMD_EXTRACT;
			OP_CLEAR:   kind = CMD_CLEAR;
			default:    known = 1'b0; // reserved code: accepted, dropped
		endcase
	end

	assign busy         = q_full;
	assign q_push       = start && !q_full && known;
	assign q_entry.kind = kind;
	assign q_entry.data = cmd.rx_byte;

endmodule

// File: hdl/fbq_cmd_queue.sv
// ----------------------------------------------------------------------------
// fbq_cmd_queue
// Small FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module fbq_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fbq_pkg::queue_entry_t push_entry,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty,
	output fbq_pkg::queue_entry_t head
);
	import fbq_pkg::*;

	queue_entry_t       entries_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0]  wr_idx_q;
	logic [QIDX_W-1:0]  rd_idx_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign head   = entries_q[rd_idx_q];
	assign do_pop = pop && !empty;

	function automatic logic [QIDX_W-1:0] idx_next(input logic [QIDX_W-1:0] i);
		if (i == QIDX_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return i + QIDX_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= idx_next(wr_idx_q);
			end
			if (do_pop) begin
				rd_idx_q <= idx_next(rd_idx_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_idx_q] <= push_entry;
		end
	end

endmodule

// File: hdl/fbq_back.sv
// ----------------------------------------------------------------------------
// fbq_back
// Executes queued commands: ring store, tail detectors, frame extraction.
// ----------------------------------------------------------------------------
`include "framed_byte_queue_core_assert.svh"

module fbq_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [5:0]            max_frame_bytes,
	input  logic                  q_empty,
	input  fbq_pkg::queue_entry_t q_head,
	output logic                  q_pop,
	output logic                  rsp_strobe,
	output fbq_pkg::rsp_item_t    rsp
);
	import fbq_pkg::*;

	logic [7:0]  ring_mem [RING_DEPTH];
	logic [7:0]  rdata_s1;
	logic        s1_valid_q, s1_valid_d;

	back_state_t state_q, state_d;
	ptr_t        wp_q, wp_d;
	ptr_t        rp_q, rp_d;
	ptr_t        fp_q, fp_d;
	logic [5:0]  pos_q, pos_d;
	logic [5:0]  len_q, len_d;
	logic [31:0] push_shift_q, push_shift_d;
	logic [31:0] ext_shift_q, ext_shift_d;
	logic [15:0] pending_q, pending_d;
	logic        rsp_strobe_q, rsp_strobe_d;
	rsp_item_t   rsp_q, rsp_d;
	logic        mem_we;
	logic        mem_re;

	logic [31:0] shifted;
	logic [5:0]  pos_inc;
	logic        hit;

	always_comb begin
		state_d      = state_q;
		wp_d         = wp_q;
		rp_d         = rp_q;
		fp_d         = fp_q;
		pos_d        = pos_q;
		len_d        = len_q;
		push_shift_d = push_shift_q;
		ext_shift_d  = ext_shift_q;
		pending_d    = pending_q;
		s1_valid_d   = 1'b0;
		rsp_strobe_d = 1'b0;
		rsp_d        = '0;
		q_pop        = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		shifted      = '0;
		pos_inc      = pos_q;
		hit          = 1'b0;

		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_head.kind)
						CMD_PUSH: begin
							if (ring_next(wp_q) != rp_q) begin
								mem_we = 1'b1;
								wp_d   = ring_next(wp_q);
							end
							shifted      = {push_shift_q[23:0], q_head.data};
							push_shift_d = shifted;
							rsp_strobe_d = 1'b1;
							rsp_d.last   = 1'b1;
							if (shifted == FRAME_TAIL) begin
								push_shift_d    = '0;
								rsp_d.tail_seen = 1'b1;
								if (pending_q != PENDING_MAX) begin
									pending_d = pending_q + 16'd1;
								end
							end
						end
						CMD_EXTRACT: begin
							if (pending_q == '0) begin
								rsp_strobe_d = 1'b1;
								rsp_d.last   = 1'b1;
							end else begin
								state_d = BK_DRAIN;
								fp_d    = rp_q;
								pos_d   = '0;
								len_d   = '0;
							end
						end
						CMD_CLEAR: begin
							wp_d      = '0;
							rp_d      = '0;
							pending_d = '0;
						end
						default: ;
					endcase
				end
			end
			BK_DRAIN: begin
				// process the byte read last cycle
				if (s1_valid_q) begin
					rp_d = ring_next(rp_q);
					if (!(pos_q == '0 && rdata_s1 != FRAME_HEAD)) begin
						if (pos_q < max_frame_bytes) begin
							rsp_strobe_d     = 1'b1;
							rsp_d.byte_valid = 1'b1;
							rsp_d.frame_byte = rdata_s1;
							pos_inc          = pos_q + 6'd1;
						end
						pos_d       = pos_inc;
						shifted     = {ext_shift_q[23:0], rdata_s1};
						ext_shift_d = shifted;
						if (shifted == FRAME_TAIL) begin
							hit         = 1'b1;
							ext_shift_d = '0;
							pending_d   = pending_q - 16'd1;
							len_d       = pos_inc;
							state_d     = BK_STATUS;
						end
					end
				end
				// fetch the next byte ahead of the read pointer
				if (!hit && fp_q != wp_q) begin
					mem_re     = 1'b1;
					fp_d       = ring_next(fp_q);
					s1_valid_d = 1'b1;
				end
				if (!s1_valid_q && fp_q == wp_q) begin
					state_d = BK_STATUS;
				end
			end
			BK_STATUS: begin
				rsp_strobe_d       = 1'b1;
				rsp_d.last         = 1'b1;
				rsp_d.frame_length = len_q;
				state_d            = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			wp_q         <= '0;
			rp_q         <= '0;
			push_shift_q <= '0;
			ext_shift_q  <= '0;
			pending_q    <= '0;
			s1_valid_q   <= 1'b0;
			rsp_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			wp_q         <= wp_d;
			rp_q         <= rp_d;
			push_shift_q <= push_shift_d;
			ext_shift_q  <= ext_shift_d;
			pending_q    <= pending_d;
			s1_valid_q   <= s1_valid_d;
			rsp_strobe_q <= rsp_strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		fp_q  <= fp_d;
		pos_q <= pos_d;
		len_q <= len_d;
		rsp_q <= rsp_d;
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wp_q] <= q_head.data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_s1 <= ring_mem[fp_q];
		end
	end

	assign rsp_strobe = rsp_strobe_q;
	assign rsp        = rsp_q;

	`FBQ_ASSERT_NOW(a_len_only_on_last,
		rsp_strobe_q && (rsp_q.frame_length != '0), rsp_q.last,
		"frame length on a non-final result")
	`FBQ_ASSERT_NEXT(a_status_follows, state_q == BK_STATUS,
		rsp_strobe_q && rsp_q.last && !rsp_q.byte_valid, "status result missing")
	`FBQ_ASSERT_NOW(a_no_read_outside_drain, state_q != BK_DRAIN, !s1_valid_q,
		"ring read in flight outside drain")
	`FBQ_ASSERT_NOW(a_drain_has_frame, state_q == BK_DRAIN, pending_q != '0,
		"draining with no pending frame")

endmodule

// File: hdl/framed_byte_queue_core.sv
// ----------------------------------------------------------------------------
// framed_byte_queue_core
// Ring buffer of received UART bytes with tail-delimited frame extraction.
// ----------------------------------------------------------------------------
// Usage: a command transfers at a rising edge with start high and busy low.
// Results come out on rsp for exactly one cycle each, marked by rsp_strobe,
// and cannot be held off: the receiver must take every one. A push gives one
// result once the command queue passes it on (tail_seen set when the byte
// closed a 0xFFFCFFFF tail). An extract with no pending frame gives one status
// result; otherwise it streams the frame bytes (from the 0xEE head, at most
// max_frame_bytes of them), then one status result with the frame length, or
// 0 if the ring ran empty first. Clear and the unused code give no result.
// Rate: pushes sustain one per cycle while no extract is running. An extract
// fetches ring bytes through the registered read port of the ring memory
// and processes each fetched byte while the next one is fetched, so the
// drain runs one byte per cycle; then it gives its status result. Commands
// land in a two-entry queue, so busy rises only once that queue is full
// behind a running extract. The ring holds up to RING_DEPTH-1 bytes; pushes
// to a full ring are dropped but still feed the tail detector. The ring
// memory has no clearing pass: the pointers alone define its contents.
// max_frame_bytes (reset 63) may be written only when the block is idle.
// ----------------------------------------------------------------------------
module framed_byte_queue_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               start,
	input  fbq_pkg::cmd_item_t cmd,
	output logic               busy,
	output logic               rsp_strobe,
	output fbq_pkg::rsp_item_t rsp
);
	import fbq_pkg::*;

	logic         [5:0] max_frame_bytes_q;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	queue_entry_t       q_entry;
	queue_entry_t       q_head;

	// single config register, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_frame_bytes_q <= cfg_wdata;
		end
	end

	// front: transfer and decode
	fbq_front u_front (
		.start   (start),
		.cmd     (cmd),
		.q_full  (q_full),
		.busy    (busy),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	// decouples front and back
	fbq_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	// back: ring, detectors, extraction sequencer, result register
	fbq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.max_frame_bytes (max_frame_bytes_q),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.rsp_strobe      (rsp_strobe),
		.rsp             (rsp)
	);

endmodule

// File: dv/tb_framed_byte_queue_core.sv
// ----------------------------------------------------------------------------
// tb_framed_byte_queue_core
// Self-checking bench for the framed byte queue. A built-in mirror of the
// ring, both tail detectors and the pending-frame count predicts every result
// of each command transfer. A monitor compares the strobed results in order.
// Directed frames, frame-size limits, pending-count build-up and random
// frame traffic run as separate tests.
// ----------------------------------------------------------------------------
module tb_framed_byte_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fbq_pkg::*;

	// the fourth operation code has no name in the package; the block ignores it
	localparam logic [1:0] OP_IGNORED  = 2'd3;
	localparam int         CYCLE_LIMIT = 100_000;
	localparam int         SETTLE_CYC  = 16;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic       start     = 1'b0;
	cmd_item_t  cmd       = '0;
	logic       busy;
	logic       rsp_strobe;
	rsp_item_t  rsp;

	framed_byte_queue_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.rsp_strobe (rsp_strobe),
		.rsp        (rsp)
	);

	always #1 clk = ~clk;

	// mirror of the block state
	logic [7:0]  ring_mirror [RING_DEPTH];
	ptr_t        wr_mirror;
	ptr_t        rd_mirror;
	logic [31:0] push_sr_mirror;
	logic [31:0] extract_sr_mirror;
	logic [15:0] frames_mirror;
	logic [5:0]  max_len_mirror;

	rsp_item_t   awaited_rsp [$];
	rsp_item_t   head_rsp;
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          items_sent     = 0;
	bit          idle_on        = 1'b1;

	// work out the results of one accepted command and queue them
	task automatic predict_cmd(input cmd_item_t c);
		rsp_item_t   r;
		ptr_t        nxt;
		logic [7:0]  b;
		int          pos;
		logic [5:0]  len;
		bit          done;
		r = '0;
		case (c.operation)
			OP_PUSH: begin
				nxt = wr_mirror + ptr_t'(1);
				// full ring drops the byte, the detector still sees it
				if (nxt != rd_mirror) begin
					ring_mirror[wr_mirror] = c.rx_byte;
					wr_mirror = nxt;
				end
				push_sr_mirror = {push_sr_mirror[23:0], c.rx_byte};
				r.last = 1'b1;
				if (push_sr_mirror == FRAME_TAIL) begin
					push_sr_mirror = '0;
					if (frames_mirror != PENDING_MAX) begin
						frames_mirror = frames_mirror + 16'd1;
					end
					r.tail_seen = 1'b1;
				end
				awaited_rsp.push_back(r);
			end
			OP_EXTRACT: begin
				pos  = 0;
				len  = '0;
				done = 1'b0;
				// with no pending frame the ring is not touched
				if (frames_mirror != '0) begin
					while (!done && rd_mirror != wr_mirror) begin
						b = ring_mirror[rd_mirror];
						rd_mirror = rd_mirror + ptr_t'(1);
						// bytes ahead of the head are skipped, detector untouched
						if (pos != 0 || b == FRAME_HEAD) begin
							if (pos < int'(max_len_mirror)) begin
								r = '0;
								r.byte_valid = 1'b1;
								r.frame_byte = b;
								awaited_rsp.push_back(r);
								pos++;
							end
							extract_sr_mirror = {extract_sr_mirror[23:0], b};
							if (extract_sr_mirror == FRAME_TAIL) begin
								extract_sr_mirror = '0;
								frames_mirror = frames_mirror - 16'd1;
								len  = 6'(pos);
								done = 1'b1;
							end
						end
					end
				end
				r = '0;
				r.last = 1'b1;
				r.frame_length = len;
				awaited_rsp.push_back(r);
			end
			OP_CLEAR: begin
				wr_mirror     = '0;
				rd_mirror     = '0;
				frames_mirror = '0;
			end
			default: begin
			end
		endcase
	endtask

	// one command transfer; start stays high on return so the next command
	// can follow back to back
	task automatic send_op(input logic [1:0] op, input logic [7:0] data);
		cmd_item_t c;
		c.operation = op;
		c.rx_byte   = data;
		if (idle_on && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_cmd(c);
		if (op != OP_IGNORED) begin
			items_sent++;
		end
	endtask

	task automatic push_byte(input logic [7:0] data);
		send_op(OP_PUSH, data);
	endtask

	// first n bytes of the tail, most significant first
	task automatic push_tail(input int n);
		for (int i = 0; i < n; i++) begin
			push_byte(FRAME_TAIL[31 - 8 * i -: 8]);
		end
	endtask

	// stop sending and wait until every predicted result is in, then let any
	// result-less command still queued inside the block finish
	task automatic settle_queue();
		start <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_max_len(input logic [5:0] v);
		start     <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		max_len_mirror = v;
	endtask

	// result monitor: results are taken at the edge that ends their cycle
	always @(posedge clk) begin
		if (arst_n && rsp_strobe) begin
			if (awaited_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("[%0t] unexpected result: valid=%0b byte=%02h last=%0b tail=%0b len=%0d",
						$realtime, rsp.byte_valid, rsp.frame_byte, rsp.last,
						rsp.tail_seen, rsp.frame_length);
				end
			end else begin
				head_rsp = awaited_rsp.pop_front();
				if (rsp.byte_valid !== head_rsp.byte_valid
						|| rsp.frame_byte !== head_rsp.frame_byte
						|| rsp.last !== head_rsp.last
						|| rsp.tail_seen !== head_rsp.tail_seen
						|| rsp.frame_length !== head_rsp.frame_length) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("[%0t] result mismatch: exp valid=%0b byte=%02h last=%0b tail=%0b len=%0d",
							$realtime, head_rsp.byte_valid, head_rsp.frame_byte,
							head_rsp.last, head_rsp.tail_seen, head_rsp.frame_length);
						$display("                       got valid=%0b byte=%02h last=%0b tail=%0b len=%0d",
							rsp.byte_valid, rsp.frame_byte, rsp.last, rsp.tail_seen,
							rsp.frame_length);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_rsp.size());
			$display("FAILURE");
			$finish;
		end
	end

	// head, tail, skipped bytes, empty extract, extract without tail, clear,
	// and the ignored operation code
	task automatic test_basic_frames();
		send_op(OP_EXTRACT, 8'hFF);
		push_byte(FRAME_HEAD);
		push_byte(8'h80);
		push_tail(4);
		send_op(OP_IGNORED, 8'h55);
		send_op(OP_EXTRACT, 8'h00);
		// a tail with no head: counted on push, skipped whole on extract
		push_byte(8'h00);
		push_byte(8'h7F);
		push_tail(4);
		send_op(OP_EXTRACT, 8'hAA);
		push_byte(FRAME_HEAD);
		send_op(OP_CLEAR, 8'h3C);
		send_op(OP_EXTRACT, 8'hC3);
		settle_queue();
	endtask

	// zero size emits nothing and finds no tail; size one cuts the frame
	task automatic test_frame_size_limits();
		write_max_len(6'd0);
		push_byte(FRAME_HEAD);
		push_tail(4);
		send_op(OP_EXTRACT, 8'h01);
		settle_queue();
		write_max_len(6'd1);
		push_byte(FRAME_HEAD);
		push_byte(8'h22);
		push_tail(4);
		send_op(OP_EXTRACT, 8'h02);
		send_op(OP_CLEAR, 8'h00);
		settle_queue();
	endtask

	// several tails counted before any extract; headless tails drain the ring
	// without a frame, and clear drops the count left over
	task automatic test_pending_count();
		write_max_len(6'd63);
		push_byte(FRAME_HEAD);
		push_byte(8'h5A);
		push_tail(4);
		repeat (3) push_tail(4);
		send_op(OP_EXTRACT, 8'h00);
		send_op(OP_EXTRACT, 8'h00);
		send_op(OP_CLEAR, 8'h00);
		send_op(OP_EXTRACT, 8'h00);
		settle_queue();
	endtask

	// mostly well-formed frames with random content, some broken frames and
	// noise, across several frame sizes
	task automatic test_random_traffic();
		logic [5:0] sizes [4];
		int         target;
		int         pick;
		int         plen;
		sizes[0] = 6'd63;
		sizes[1] = 6'd1;
		sizes[2] = 6'($urandom_range(2, 62));
		sizes[3] = 6'($urandom_range(1, 63));
		for (int phase = 0; phase < 4; phase++) begin
			settle_queue();
			write_max_len(sizes[phase]);
			// one phase runs with no idle cycles at all
			idle_on = (phase != 2);
			target  = items_sent + 25;
			while (items_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					if ($urandom_range(0, 99) < 30) begin
						repeat ($urandom_range(1, 2)) push_byte(8'($urandom));
					end
					push_byte(FRAME_HEAD);
					// a few frames run past the largest size
					plen = ($urandom_range(0, 99) < 6) ? $urandom_range(60, 70)
						: $urandom_range(0, 8);
					repeat (plen) push_byte(8'($urandom));
					push_tail(4);
					if ($urandom_range(0, 99) < 60) begin
						send_op(OP_EXTRACT, 8'($urandom));
					end
				end else if (pick < 80) begin
					push_byte(FRAME_HEAD);
					repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
					push_tail($urandom_range(1, 3));
				end else if (pick < 88) begin
					send_op(OP_EXTRACT, 8'($urandom));
				end else if (pick < 93) begin
					send_op(OP_CLEAR, 8'($urandom));
				end else if (pick < 97) begin
					send_op(OP_IGNORED, 8'($urandom));
				end else begin
					push_byte(8'($urandom));
				end
			end
		end
		idle_on = 1'b1;
		// extract up to four of the frames that are left
		repeat (4) send_op(OP_EXTRACT, 8'($urandom));
		settle_queue();
	endtask

	initial begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_mirror[i] = '0;
		end
		wr_mirror         = '0;
		rd_mirror         = '0;
		push_sr_mirror    = '0;
		extract_sr_mirror = '0;
		frames_mirror     = '0;
		max_len_mirror    = MAX_FRAME_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_frame_size_limits();
		test_random_traffic();
		test_pending_count();

		settle_queue();
		if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/fbq_pkg.sv
hdl/fbq_front.sv
hdl/fbq_cmd_queue.sv
hdl/fbq_back.sv
hdl/framed_byte_queue_core.sv
dv/tb_framed_byte_queue_core.sv
